/* hw/rtl/hcac_pkg.sv */
// ----------------------------------------------------------------------------
// hcac_pkg: shared definitions for the half-cycle asymmetry calibrator
// Store geometry, field widths, command, status and sequencer state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hcac_pkg;

    // store geometry
    localparam int STORE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // field widths
    localparam int TIME_W      = 48;
    localparam int IVAL_W      = 26;
    localparam int LIMIT_W     = 20;
    localparam int ASYM_W      = 25;
    localparam int CNT_OUT_W   = 8;
    localparam int STATUS_W    = 2;

    // accumulator and serial unit widths
    localparam int SQ_W        = 2 * IVAL_W + CNT_W;
    localparam int STEP_W      = $clog2(SQ_W);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(50000);

    typedef enum logic {
        CMD_EDGE   = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_CALIBRATED = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_UNSTABLE   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SUM,
        S_DIVM,
        S_DEV,
        S_DIVS,
        S_ROOT,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/hcac_ram.sv */
// ----------------------------------------------------------------------------
// hcac_ram: generic single-port synchronous RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hcac_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

/* hw/rtl/half_cycle_asymmetry_calibrator.sv */
// Edge word: accepted back to back while idle.
// Finish word: per store, zero mean and spread if empty, else two RAM read passes,
// two bit-serial divides and a bit-serial root; then the report, which waits while
// the receiver stalls. Input stalled meanwhile.
// Reset (synchronous, active low) clears counts, reference and output valid,
// and loads the deviation limit with 50000; the store RAMs are not cleared.
// ----------------------------------------------------------------------------
// half_cycle_asymmetry_calibrator: half-cycle interval statistics
// Stores edge intervals by level, on finish reports means, spreads, status
// and asymmetry, then empties both stores.
// ----------------------------------------------------------------------------
`default_nettype none

module half_cycle_asymmetry_calibrator
    import hcac_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input words
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_cmd,
    input  wire logic [TIME_W-1:0]    i_edge_time,
    input  wire logic                 i_level_after,
    // result words
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [STATUS_W-1:0]       o_status,
    output logic signed [ASYM_W-1:0]  o_asymmetry,
    output logic [IVAL_W-1:0]         o_mean_high,
    output logic [IVAL_W-1:0]         o_mean_low,
    output logic [IVAL_W-1:0]         o_spread_high,
    output logic [IVAL_W-1:0]         o_spread_low,
    output logic [CNT_OUT_W-1:0]      o_count_high,
    output logic [CNT_OUT_W-1:0]      o_count_low,
    // configuration
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [LIMIT_W-1:0]   i_cfg_deviation_limit
);

    // control registers
    t_state              r_state, n_state;
    logic                r_have_ref, n_have_ref;
    logic [TIME_W-1:0]   r_last, n_last;
    logic [CNT_W-1:0]    r_cnt_hi, n_cnt_hi;
    logic [CNT_W-1:0]    r_cnt_lo, n_cnt_lo;
    logic [LIMIT_W-1:0]  r_limit;
    logic                r_sel, n_sel;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_v1, n_v1;
    logic                r_v2, n_v2;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_ovalid, n_ovalid;

    // datapath registers
    logic [SQ_W-1:0]     r_acc, n_acc;
    logic [2*IVAL_W-1:0] r_sqr, n_sqr;
    logic [SQ_W-1:0]     r_quo, n_quo;
    logic [CNT_W-1:0]    r_rem, n_rem;
    logic [IVAL_W-1:0]   r_mean, n_mean;
    logic [2*IVAL_W-1:0] r_op, n_op;
    logic [IVAL_W:0]     r_rrem, n_rrem;
    logic [IVAL_W-1:0]   r_root, n_root;
    logic [IVAL_W-1:0]   r_mean_hi, n_mean_hi, r_mean_lo, n_mean_lo;
    logic [IVAL_W-1:0]   r_spr_hi, n_spr_hi, r_spr_lo, n_spr_lo;
    logic [STATUS_W-1:0] r_ostatus, n_ostatus;
    logic [ASYM_W-1:0]   r_oasym, n_oasym;
    logic [IVAL_W-1:0]   r_omh, n_omh, r_oml, n_oml, r_osh, n_osh, r_osl, n_osl;
    logic [CNT_W-1:0]    r_och, n_och, r_ocl, n_ocl;

    // RAM ports
    logic                we_hi, we_lo;
    logic [ADDR_W-1:0]   addr_hi, addr_lo;
    logic [IVAL_W-1:0]   wdata, q_hi, q_lo;

    // combinational helpers
    logic [TIME_W-1:0]   diff;
    logic [CNT_W-1:0]    n_store;
    logic [IVAL_W-1:0]   rdata, dev;
    logic [CNT_W:0]      dtrial;
    logic                dge;
    logic [IVAL_W+2:0]   rtrial, rtest;
    logic                rge;
    logic [IVAL_W:0]     mdiff;
    logic [IVAL_W:0]     mmag;
    logic [ASYM_W-1:0]   mq;
    logic                pass_done;
    logic                edge_wr;

    hcac_ram #(.WIDTH(IVAL_W), .DEPTH(STORE_DEPTH)) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (we_hi),
        .i_addr  (addr_hi),
        .i_wdata (wdata),
        .o_rdata (q_hi)
    );

    hcac_ram #(.WIDTH(IVAL_W), .DEPTH(STORE_DEPTH)) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (we_lo),
        .i_addr  (addr_lo),
        .i_wdata (wdata),
        .o_rdata (q_lo)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_asymmetry = r_oasym;
    assign o_mean_high = r_omh;
    assign o_mean_low  = r_oml;
    assign o_spread_high = r_osh;
    assign o_spread_low  = r_osl;
    assign o_count_high  = CNT_OUT_W'(r_och);
    assign o_count_low   = CNT_OUT_W'(r_ocl);

    // interval with saturation
    assign diff  = i_edge_time - r_last;
    assign wdata = (diff[TIME_W-1:IVAL_W] != '0) ? {IVAL_W{1'b1}} : diff[IVAL_W-1:0];

    assign edge_wr = (r_state == S_IDLE) && i_valid && (i_cmd == CMD_EDGE) && r_have_ref
                     && (r_cnt_hi != CNT_W'(STORE_DEPTH))
                     && (r_cnt_lo != CNT_W'(STORE_DEPTH));

    // store being summarized
    assign n_store = r_sel ? r_cnt_lo : r_cnt_hi;
    assign rdata   = r_sel ? q_lo : q_hi;
    assign dev     = (rdata >= r_mean) ? (rdata - r_mean) : (r_mean - rdata);

    // RAM address: write pointer on edges, pass index otherwise
    assign we_hi   = edge_wr && i_level_after;
    assign we_lo   = edge_wr && !i_level_after;
    assign addr_hi = we_hi ? r_cnt_hi[ADDR_W-1:0] : r_idx[ADDR_W-1:0];
    assign addr_lo = we_lo ? r_cnt_lo[ADDR_W-1:0] : r_idx[ADDR_W-1:0];

    // restoring divide step by the store count
    assign dtrial = {r_rem, r_quo[SQ_W-1]};
    assign dge    = (dtrial >= {1'b0, n_store});

    // square root step
    assign rtrial = {r_rrem, r_op[2*IVAL_W-1:2*IVAL_W-2]};
    assign rtest  = {1'b0, r_root, 2'b01};
    assign rge    = (rtrial >= rtest);

    // asymmetry, truncated toward zero
    assign mdiff = {1'b0, r_mean_lo} - {1'b0, r_mean_hi};
    assign mmag  = mdiff[IVAL_W] ? (~mdiff + 1'b1) : mdiff;
    assign mq    = ASYM_W'(mmag >> 2);

    assign pass_done = (r_idx == n_store) && !r_v1 && !r_v2;

    // next state and datapath
    always_comb begin
        n_state    = r_state;
        n_have_ref = r_have_ref;
        n_last     = r_last;
        n_cnt_hi   = r_cnt_hi;
        n_cnt_lo   = r_cnt_lo;
        n_sel      = r_sel;
        n_idx      = r_idx;
        n_v1       = 1'b0;
        n_v2       = 1'b0;
        n_step     = r_step;
        n_ovalid   = r_ovalid && i_stall;
        n_acc      = r_acc;
        n_sqr      = r_sqr;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_mean     = r_mean;
        n_op       = r_op;
        n_rrem     = r_rrem;
        n_root     = r_root;
        n_mean_hi  = r_mean_hi;
        n_mean_lo  = r_mean_lo;
        n_spr_hi   = r_spr_hi;
        n_spr_lo   = r_spr_lo;
        n_ostatus  = r_ostatus;
        n_oasym    = r_oasym;
        n_omh      = r_omh;
        n_oml      = r_oml;
        n_osh      = r_osh;
        n_osl      = r_osl;
        n_och      = r_och;
        n_ocl      = r_ocl;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_cmd == CMD_FINISH) begin
                        n_sel   = 1'b0;
                        n_state = S_START;
                    end else if (!r_have_ref) begin
                        n_last     = i_edge_time;
                        n_have_ref = 1'b1;
                    end else if (edge_wr) begin
                        n_last = i_edge_time;
                        if (i_level_after) begin
                            n_cnt_hi = r_cnt_hi + 1'b1;
                        end else begin
                            n_cnt_lo = r_cnt_lo + 1'b1;
                        end
                    end
                end
            end
            S_START: begin
                if (n_store == '0) begin
                    if (r_sel) begin
                        n_mean_lo = '0;
                        n_spr_lo  = '0;
                        n_state   = S_OUT;
                    end else begin
                        n_mean_hi = '0;
                        n_spr_hi  = '0;
                        n_sel     = 1'b1;
                    end
                end else begin
                    n_idx   = '0;
                    n_acc   = '0;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (r_idx != n_store) begin
                    n_idx = r_idx + 1'b1;
                    n_v1  = 1'b1;
                end
                if (r_v1) begin
                    n_acc = r_acc + SQ_W'(rdata);
                end
                if (pass_done) begin
                    n_quo   = r_acc;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = S_DIVM;
                end
            end
            S_DIVM, S_DIVS: begin
                n_rem  = dge ? CNT_W'(dtrial - {1'b0, n_store}) : CNT_W'(dtrial);
                n_quo  = {r_quo[SQ_W-2:0], dge};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(SQ_W - 1)) begin
                    if (r_state == S_DIVM) begin
                        n_mean  = n_quo[IVAL_W-1:0];
                        n_idx   = '0;
                        n_acc   = '0;
                        n_state = S_DEV;
                    end else begin
                        n_op    = n_quo[2*IVAL_W-1:0];
                        n_rrem  = '0;
                        n_root  = '0;
                        n_step  = '0;
                        n_state = S_ROOT;
                    end
                end
            end
            S_DEV: begin
                if (r_idx != n_store) begin
                    n_idx = r_idx + 1'b1;
                    n_v1  = 1'b1;
                end
                if (r_v1) begin
                    n_sqr = dev * dev;
                    n_v2  = 1'b1;
                end
                if (r_v2) begin
                    n_acc = r_acc + SQ_W'(r_sqr);
                end
                if (pass_done) begin
                    n_quo   = r_acc;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = S_DIVS;
                end
            end
            S_ROOT: begin
                n_rrem = rge ? (IVAL_W+1)'(rtrial - rtest) : (IVAL_W+1)'(rtrial);
                n_root = {r_root[IVAL_W-2:0], rge};
                n_op   = {r_op[2*IVAL_W-3:0], 2'b00};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(IVAL_W - 1)) begin
                    if (r_sel) begin
                        n_mean_lo = r_mean;
                        n_spr_lo  = n_root;
                        n_state   = S_OUT;
                    end else begin
                        n_mean_hi = r_mean;
                        n_spr_hi  = n_root;
                        n_sel     = 1'b1;
                        n_state   = S_START;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_oasym  = '0;
                    if (r_cnt_hi == '0 || r_cnt_lo == '0) begin
                        n_ostatus = ST_EMPTY;
                    end else if (r_spr_hi < IVAL_W'(r_limit) && r_spr_lo < IVAL_W'(r_limit)) begin
                        n_ostatus = ST_CALIBRATED;
                        n_oasym   = mdiff[IVAL_W] ? (~mq + 1'b1) : mq;
                    end else begin
                        n_ostatus = ST_UNSTABLE;
                    end
                    n_omh    = r_mean_hi;
                    n_oml    = r_mean_lo;
                    n_osh    = r_spr_hi;
                    n_osl    = r_spr_lo;
                    n_och    = r_cnt_hi;
                    n_ocl    = r_cnt_lo;
                    n_cnt_hi = '0;
                    n_cnt_lo = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_have_ref <= 1'b0;
            r_last     <= '0;
            r_cnt_hi   <= '0;
            r_cnt_lo   <= '0;
            r_limit    <= LIMIT_RESET;
            r_sel      <= 1'b0;
            r_idx      <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_step     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_have_ref <= n_have_ref;
            r_last     <= n_last;
            r_cnt_hi   <= n_cnt_hi;
            r_cnt_lo   <= n_cnt_lo;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_deviation_limit;
            end
            r_sel      <= n_sel;
            r_idx      <= n_idx;
            r_v1       <= n_v1;
            r_v2       <= n_v2;
            r_step     <= n_step;
            r_ovalid   <= n_ovalid;
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_sqr     <= n_sqr;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_mean    <= n_mean;
        r_op      <= n_op;
        r_rrem    <= n_rrem;
        r_root    <= n_root;
        r_mean_hi <= n_mean_hi;
        r_mean_lo <= n_mean_lo;
        r_spr_hi  <= n_spr_hi;
        r_spr_lo  <= n_spr_lo;
        r_ostatus <= n_ostatus;
        r_oasym   <= n_oasym;
        r_omh     <= n_omh;
        r_oml     <= n_oml;
        r_osh     <= n_osh;
        r_osl     <= n_osl;
        r_och     <= n_och;
        r_ocl     <= n_ocl;
    end

`ifndef NO_ASSERTIONS
    // store counts never run past the depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_hi <= CNT_W'(STORE_DEPTH)) && (r_cnt_lo <= CNT_W'(STORE_DEPTH)))
        else $error("store count beyond depth");

    // a finished report empties both stores
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && n_state == S_IDLE) |=> (r_cnt_hi == '0 && r_cnt_lo == '0))
        else $error("stores not cleared after report");

    // asymmetry only reported when calibrated
    a_asym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_CALIBRATED) |-> (o_asymmetry == '0))
        else $error("asymmetry nonzero without calibration");

    // no RAM write outside idle
    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we_hi || we_lo) |-> (r_state == S_IDLE && !(we_hi && we_lo)))
        else $error("store write outside idle");
`endif

endmodule

`default_nettype wire

/* sim/half_cycle_asymmetry_calibrator_tb.sv */
// ----------------------------------------------------------------------------
// half_cycle_asymmetry_calibrator_tb: self-checking bench for the calibrator
// Drives edge and finish words with random bursts and receiver stalls, keeps
// its own interval stores and statistics, and checks every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module half_cycle_asymmetry_calibrator_tb;
    import hcac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one expected result word
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [ASYM_W-1:0] asym;
        logic [IVAL_W-1:0]        mh, ml, sh, sl;
        logic [CNT_OUT_W-1:0]     ch, cl;
    } t_calib;

    // scoreboard: own copy of block state, queue of expected calibrations
    class calib_board;
        logic [TIME_W-1:0]  last_t;
        bit                 have_ref;
        logic [IVAL_W-1:0]  hi_iv[STORE_DEPTH];
        logic [IVAL_W-1:0]  lo_iv[STORE_DEPTH];
        int                 hi_n, lo_n;
        logic [LIMIT_W-1:0] limit;
        t_calib             pending[$];
        int                 errors, checked;

        function void clear();
            last_t = '0; have_ref = 0; hi_n = 0; lo_n = 0; limit = LIMIT_RESET;
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b; r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void stats(bit hi, int n, output longint unsigned m,
                            output longint unsigned s);
            longint unsigned sum, sq, x, d;
            sum = 0; sq = 0; m = 0; s = 0;
            if (n == 0) return;
            for (int i = 0; i < n; i++) sum += hi ? hi_iv[i] : lo_iv[i];
            m = sum / n;
            for (int i = 0; i < n; i++) begin
                x = hi ? hi_iv[i] : lo_iv[i];
                d = (x >= m) ? x - m : m - x;
                sq += d * d;
            end
            s = root(sq / n);
        endfunction

        // note one accepted input word
        function void note_word(t_cmd cmd, logic [TIME_W-1:0] t, logic lvl);
            logic [TIME_W-1:0] iv;
            longint unsigned mh, ml, sh, sl;
            t_calib c;
            if (cmd == CMD_EDGE) begin
                if (!have_ref) begin
                    last_t = t; have_ref = 1; return;
                end
                if (hi_n >= STORE_DEPTH || lo_n >= STORE_DEPTH) return;
                iv = t - last_t;
                if (iv > {IVAL_W{1'b1}}) iv = {IVAL_W{1'b1}};
                last_t = t;
                if (lvl) hi_iv[hi_n++] = iv[IVAL_W-1:0];
                else lo_iv[lo_n++] = iv[IVAL_W-1:0];
                return;
            end
            stats(1, hi_n, mh, sh);
            stats(0, lo_n, ml, sl);
            c.asym = '0;
            if (hi_n == 0 || lo_n == 0) c.status = ST_EMPTY;
            else if (sh < limit && sl < limit) begin
                c.status = ST_CALIBRATED;
                if (ml >= mh) c.asym = ASYM_W'((ml - mh) / 4);
                else c.asym = -ASYM_W'((mh - ml) / 4);
            end else c.status = ST_UNSTABLE;
            c.mh = IVAL_W'(mh); c.ml = IVAL_W'(ml);
            c.sh = IVAL_W'(sh); c.sl = IVAL_W'(sl);
            c.ch = CNT_OUT_W'(hi_n); c.cl = CNT_OUT_W'(lo_n);
            pending.push_back(c);
            hi_n = 0; lo_n = 0;
        endfunction

        // compare one result word with the oldest expectation
        function void check_result(t_calib got);
            t_calib e;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++; return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                $display("%0t: mismatch expected %p actual %p", $time, e, got);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk, i_rst_n;
    logic                 i_valid, i_cmd, i_level_after;
    logic [TIME_W-1:0]    i_edge_time;
    logic                 o_stall, o_valid, i_stall;
    logic [STATUS_W-1:0]  o_status;
    logic signed [ASYM_W-1:0] o_asymmetry;
    logic [IVAL_W-1:0]    o_mean_high, o_mean_low, o_spread_high, o_spread_low;
    logic [CNT_OUT_W-1:0] o_count_high, o_count_low;
    logic                 i_cfg_valid, o_cfg_ready;
    logic [LIMIT_W-1:0]   i_cfg_deviation_limit;

    half_cycle_asymmetry_calibrator dut (.*);

    calib_board board = new();
    longint cycles;
    int     hold_off;       // long receiver hold-off, in cycles
    int     stall_mode;
    int     sent;           // input words accepted
    logic [TIME_W-1:0] now_t;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // cycle limit: far above a full run, including all stalls
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3_000_000) begin
            $display("half_cycle_asymmetry_calibrator_tb NOT OK");
            $finish;
        end
    end

    // receiver: stall pattern changes, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall  <= 1;
        end else begin
            if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: i_stall <= 0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 1) == 0);
                default: i_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
        if (i_rst_n && o_valid && !i_stall)
            board.check_result({o_status, o_asymmetry, o_mean_high, o_mean_low,
                                o_spread_high, o_spread_low, o_count_high, o_count_low});
    end

    // send one word, waiting for acceptance; valid stays up for the next word
    task automatic send_word(t_cmd cmd, logic [TIME_W-1:0] t, logic lvl);
        i_valid <= 1; i_cmd <= cmd; i_edge_time <= t; i_level_after <= lvl;
        do @(posedge i_clk); while (o_stall);
        board.note_word(cmd, t, lvl);
        sent++;
    endtask

    task automatic edge_after(longint unsigned dt, logic lvl);
        now_t = TIME_W'(now_t + dt);
        send_word(CMD_EDGE, now_t, lvl);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (900) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        i_cfg_valid <= 1; i_cfg_deviation_limit <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.limit = v;
        i_cfg_valid <= 0;
    endtask

    // random gap between bursts
    task automatic gap();
        if ($urandom_range(0, 2) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // a mains-like sequence with random content, then finish
    task automatic mains_run(int n, int jitter, int base_hi, int base_lo);
        for (int i = 0; i < n; i++) begin
            edge_after(base_hi + $urandom_range(0, jitter), 1'b1);
            edge_after(base_lo + $urandom_range(0, jitter), 1'b0);
            gap();
        end
        send_word(CMD_FINISH, TIME_W'($urandom()), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        cycles = 0; hold_off = 0; stall_mode = 0; sent = 0;
        i_rst_n = 0; i_valid = 0; i_cmd = CMD_EDGE; i_edge_time = '0;
        i_level_after = 0; i_stall = 0; i_cfg_valid = 0;
        i_cfg_deviation_limit = '0;
        board.clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: finish with empty stores, reference edge at max time
        send_word(CMD_FINISH, '1, 1);
        now_t = {TIME_W{1'b1}};
        send_word(CMD_EDGE, now_t, 1);
        edge_after(10_000_000, 1);       // wraps across zero
        send_word(CMD_FINISH, '0, 0);    // low store empty
        edge_after(64'd1 << 40, 0);      // saturates
        edge_after(0, 1);
        edge_after(1, 0);
        send_word(CMD_FINISH, '0, 0);    // unstable at reset limit
        edge_after(9_000_000, 1);
        edge_after(11_000_000, 0);
        send_word(CMD_FINISH, '0, 0);    // calibrated, positive asymmetry
        edge_after(11_000_000, 1);
        edge_after(9_000_000, 0);
        send_word(CMD_FINISH, '0, 0);    // negative asymmetry
        drain();

        // extremes of the limit register
        write_limit('0);
        edge_after(5, 1); edge_after(5, 0);
        send_word(CMD_FINISH, '0, 0);    // spread 0 not below 0
        drain();
        write_limit('1);
        // fill a store: later edges ignored
        mains_run(STORE_DEPTH + 3, 1_000_000, 9_500_000, 9_500_000);
        drain();
        write_limit(LIMIT_RESET);

        // random phases with a few limit settings
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) hold_off = 3000;   // receiver holds off; block backs up
            for (int r = 0; r < 26; r++) begin
                case ($urandom_range(0, 9))
                    0: begin              // noise
                        for (int k = 0; k < 4; k++) begin
                            if ($urandom_range(0, 4) == 0)
                                send_word(CMD_FINISH, TIME_W'({$urandom, $urandom}),
                                          1'($urandom));
                            else
                                edge_after({$urandom, $urandom} >>
                                           $urandom_range(0, 63), 1'($urandom));
                        end
                    end
                    1: begin              // one level only
                        for (int k = 0; k < 5; k++) edge_after($urandom_range(1, 1000), 1);
                        send_word(CMD_FINISH, '0, 0);
                    end
                    default: begin
                        mains_run($urandom_range(1, 10), $urandom_range(0, 200_000),
                                  $urandom_range(8_000_000, 12_000_000),
                                  $urandom_range(8_000_000, 12_000_000));
                    end
                endcase
            end
            // sender waits for every outstanding result
            drain();
            write_limit($urandom_range(0, 1) ? LIMIT_W'($urandom_range(0, 200_000))
                                             : LIMIT_W'($urandom));
        end

        drain();
        $display("Sent %0d words over directed and random phases, %0d result words checked.",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("half_cycle_asymmetry_calibrator_tb OK");
        else
            $display("half_cycle_asymmetry_calibrator_tb NOT OK");
        $finish;
    end
endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/hcac_pkg.sv
hw/rtl/hcac_ram.sv
hw/rtl/half_cycle_asymmetry_calibrator.sv
sim/half_cycle_asymmetry_calibrator_tb.sv
